>>> sv/ihp_pkg.sv
package ihp_pkg;

  // Walk phases of the JPEG segment scanner
  localparam logic [2:0] PH_PREFIX   = 3'd0;
  localparam logic [2:0] PH_MARKER   = 3'd1;
  localparam logic [2:0] PH_LEN_HIGH = 3'd2;
  localparam logic [2:0] PH_LEN_LOW  = 3'd3;
  localparam logic [2:0] PH_FRAME    = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;

  // Image kind codes
  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_PNG     = 3'd1;
  localparam logic [2:0] KIND_JPEG    = 3'd2;
  localparam logic [2:0] KIND_GIF     = 3'd3;
  localparam logic [2:0] KIND_BMP     = 3'd4;

  // Magic and marker bytes
  localparam logic [7:0] PNG_MAGIC0  = 8'h89;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_N      = 8'h4E;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_I      = 8'h49;
  localparam logic [7:0] CHAR_F      = 8'h46;
  localparam logic [7:0] CHAR_B      = 8'h42;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_HI_MSK = 8'hF0;
  localparam logic [7:0] MARK_SOF    = 8'hC0;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_JPG    = 8'hC8;
  localparam logic [7:0] MARK_DAC    = 8'hCC;

  // Lengths and offsets
  localparam logic [31:0] PNG_MIN_LEN   = 32'd8;
  localparam logic [31:0] PNG_DIM_LEN   = 32'd24;
  localparam logic [31:0] JPEG_MIN_LEN  = 32'd3;
  localparam logic [31:0] GIF_MIN_LEN   = 32'd4;
  localparam logic [31:0] BMP_MIN_LEN   = 32'd2;
  localparam logic [31:0] PNG_W_FIRST   = 32'd16;
  localparam logic [31:0] PNG_H_FIRST   = 32'd20;
  localparam logic [31:0] SEG_START_RST = 32'd2;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [15:0] SEG_LEN_MIN   = 16'd2;
  localparam logic [31:0] OFF_TALL_HI   = 32'd5;
  localparam logic [31:0] OFF_TALL_LO   = 32'd6;
  localparam logic [31:0] OFF_WIDE_HI   = 32'd7;
  localparam logic [31:0] OFF_WIDE_LO   = 32'd8;

  // One result item
  typedef struct packed {
    logic [2:0]  image_kind;
    logic [31:0] width;
    logic [31:0] height;
  } result_t;

endpackage

>>> sv/ihp_if.sv
// Input byte channel
interface ihp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel
interface ihp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  image_kind;
  logic [31:0] width;
  logic [31:0] height;

  modport source (output valid, output image_kind, output width, output height,
                  input ready);
  modport sink   (input valid, input image_kind, input width, input height,
                  output ready);
endinterface

>>> sv/image_header_probe_top.sv
// Channel  Dir  Payload                          Transfer
// in_ch    in   data_byte[7:0], last_byte        valid && ready
// out_ch   out  image_kind[2:0], width, height   valid && ready
//
// One byte is taken per cycle while in_ch is ready; the last byte's result
// is registered. All scan state lives in one register set updated per byte.
// Reset (rst_n low, synchronous) clears the scanner and both result slots.
// A result register plus a skid slot let bytes keep flowing while a result
// waits; in_ch stalls only when both slots hold undelivered results.
module image_header_probe_top (
  input  logic     clk,
  input  logic     rst_n,
  ihp_in_if.sink   in_ch,
  ihp_out_if.source out_ch
);

  logic [31:0] count_r,    count_nxt;
  logic [31:0] lead_r,     lead_nxt;
  logic [31:0] png_wide_r, png_wide_nxt;
  logic [31:0] png_tall_r, png_tall_nxt;
  logic [31:0] seg_r,      seg_nxt;
  logic [2:0]  phase_r,    phase_nxt;
  logic [7:0]  len_high_r, len_high_nxt;
  logic [15:0] jpg_tall_r, jpg_tall_nxt;
  logic [15:0] jpg_wide_r, jpg_wide_nxt;
  logic        found_r,    found_nxt;

  logic             out_valid_r, skid_valid_r;
  ihp_pkg::result_t out_r, skid_r, res;

  logic        accept;
  logic        res_fire;
  logic [7:0]  b;
  logic [31:0] pos;
  logic [15:0] seg_len;
  logic [32:0] seg_next;
  logic [31:0] off;
  logic        is_sof;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign res_fire    = accept && in_ch.last_byte;
  assign b           = in_ch.data_byte;
  assign pos         = count_r;
  assign seg_len     = {len_high_r, b};
  assign seg_next    = {1'b0, seg_r} + 33'd2 + {17'd0, seg_len};
  assign off         = pos - seg_r;
  assign is_sof      = ((b & ihp_pkg::MARK_HI_MSK) == ihp_pkg::MARK_SOF) &&
                       (b != ihp_pkg::MARK_DHT) && (b != ihp_pkg::MARK_JPG) &&
                       (b != ihp_pkg::MARK_DAC);

  // Advance counter, header capture and the segment walk for one byte
  always_comb begin
    count_nxt    = (count_r == ihp_pkg::COUNT_MAX) ? count_r : count_r + 32'd1;
    lead_nxt     = lead_r;
    png_wide_nxt = png_wide_r;
    png_tall_nxt = png_tall_r;
    seg_nxt      = seg_r;
    phase_nxt    = phase_r;
    len_high_nxt = len_high_r;
    jpg_tall_nxt = jpg_tall_r;
    jpg_wide_nxt = jpg_wide_r;
    found_nxt    = found_r;

    if (pos < 32'd4) begin
      lead_nxt[8*pos[1:0] +: 8] = lead_r[8*pos[1:0] +: 8] | b;
    end
    if (pos >= ihp_pkg::PNG_W_FIRST && pos < ihp_pkg::PNG_H_FIRST) begin
      png_wide_nxt = {png_wide_r[23:0], b};
    end else if (pos >= ihp_pkg::PNG_H_FIRST && pos < ihp_pkg::PNG_DIM_LEN) begin
      png_tall_nxt = {png_tall_r[23:0], b};
    end

    unique case (phase_r)
      ihp_pkg::PH_PREFIX: begin
        if (pos == seg_r) begin
          phase_nxt = (b == ihp_pkg::MARK_PREFIX) ? ihp_pkg::PH_MARKER
                                                  : ihp_pkg::PH_DONE;
        end
      end
      ihp_pkg::PH_MARKER: begin
        phase_nxt = is_sof ? ihp_pkg::PH_FRAME : ihp_pkg::PH_LEN_HIGH;
      end
      ihp_pkg::PH_LEN_HIGH: begin
        len_high_nxt = b;
        phase_nxt    = ihp_pkg::PH_LEN_LOW;
      end
      ihp_pkg::PH_LEN_LOW: begin
        if (seg_len < ihp_pkg::SEG_LEN_MIN || seg_next[32]) begin
          phase_nxt = ihp_pkg::PH_DONE;
        end else begin
          seg_nxt   = seg_next[31:0];
          phase_nxt = ihp_pkg::PH_PREFIX;
        end
      end
      ihp_pkg::PH_FRAME: begin
        if (off == ihp_pkg::OFF_TALL_HI || off == ihp_pkg::OFF_TALL_LO) begin
          jpg_tall_nxt = {jpg_tall_r[7:0], b};
        end else if (off == ihp_pkg::OFF_WIDE_HI || off == ihp_pkg::OFF_WIDE_LO) begin
          jpg_wide_nxt = {jpg_wide_r[7:0], b};
        end
        if (off == ihp_pkg::OFF_WIDE_LO) begin
          found_nxt = 1'b1;
          phase_nxt = ihp_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Classify the file from the updated header bytes and length
  always_comb begin
    res.image_kind = ihp_pkg::KIND_UNKNOWN;
    res.width      = 32'd0;
    res.height     = 32'd0;
    if (count_nxt >= ihp_pkg::PNG_MIN_LEN && lead_nxt[7:0] == ihp_pkg::PNG_MAGIC0 &&
        lead_nxt[15:8] == ihp_pkg::CHAR_P && lead_nxt[23:16] == ihp_pkg::CHAR_N &&
        lead_nxt[31:24] == ihp_pkg::CHAR_G) begin
      res.image_kind = ihp_pkg::KIND_PNG;
      if (count_nxt >= ihp_pkg::PNG_DIM_LEN) begin
        res.width  = png_wide_nxt;
        res.height = png_tall_nxt;
      end
    end else if (count_nxt >= ihp_pkg::JPEG_MIN_LEN &&
                 lead_nxt[7:0] == ihp_pkg::MARK_PREFIX &&
                 lead_nxt[15:8] == ihp_pkg::MARK_SOI &&
                 lead_nxt[23:16] == ihp_pkg::MARK_PREFIX) begin
      res.image_kind = ihp_pkg::KIND_JPEG;
      if (found_nxt) begin
        res.width  = {16'd0, jpg_wide_nxt};
        res.height = {16'd0, jpg_tall_nxt};
      end
    end else if (count_nxt >= ihp_pkg::GIF_MIN_LEN && lead_nxt[7:0] == ihp_pkg::CHAR_G &&
                 lead_nxt[15:8] == ihp_pkg::CHAR_I &&
                 lead_nxt[23:16] == ihp_pkg::CHAR_F) begin
      res.image_kind = ihp_pkg::KIND_GIF;
    end else if (count_nxt >= ihp_pkg::BMP_MIN_LEN && lead_nxt[7:0] == ihp_pkg::CHAR_B &&
                 lead_nxt[15:8] == ihp_pkg::CHAR_M) begin
      res.image_kind = ihp_pkg::KIND_BMP;
    end
  end

  // Update scan state per transfer; drop back to reset values after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || res_fire) begin
      count_r    <= 32'd0;
      lead_r     <= 32'd0;
      png_wide_r <= 32'd0;
      png_tall_r <= 32'd0;
      seg_r      <= ihp_pkg::SEG_START_RST;
      phase_r    <= ihp_pkg::PH_PREFIX;
      len_high_r <= 8'd0;
      jpg_tall_r <= 16'd0;
      jpg_wide_r <= 16'd0;
      found_r    <= 1'b0;
    end else if (accept) begin
      count_r    <= count_nxt;
      lead_r     <= lead_nxt;
      png_wide_r <= png_wide_nxt;
      png_tall_r <= png_tall_nxt;
      seg_r      <= seg_nxt;
      phase_r    <= phase_nxt;
      len_high_r <= len_high_nxt;
      jpg_tall_r <= jpg_tall_nxt;
      jpg_wide_r <= jpg_wide_nxt;
      found_r    <= found_nxt;
    end
  end

  // Result register with skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_fire;
        if (res_fire) begin
          out_r <= res;
        end
      end
    end else if (res_fire) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.image_kind = out_r.image_kind;
  assign out_ch.width      = out_r.width;
  assign out_ch.height     = out_r.height;

endmodule
